### hdl/svit_pkg.sv
// Shared constants, types and key helpers for the sorted value intern table.
`timescale 1ns / 1ps

package svit_pkg;

   localparam int CAPACITY    = 1024;
   localparam int VALUE_WIDTH = 32;
   localparam int RESET_COUNT = 3;

   localparam int ADDR_WIDTH  = $clog2(CAPACITY);
   localparam int COUNT_WIDTH = ADDR_WIDTH + 1;
   localparam int KEY_WIDTH   = VALUE_WIDTH + 1;
   localparam int PAIR_WIDTH  = KEY_WIDTH + ADDR_WIDTH;
   localparam int INIT_WIDTH  = $clog2(RESET_COUNT);

   localparam int REQ_DATA_WIDTH = 48;
   localparam int RSP_DATA_WIDTH = 48;

   typedef logic [KEY_WIDTH-1:0]   key_type;
   typedef logic [ADDR_WIDTH-1:0]  addr_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef enum logic [8:0] {
      ST_INIT    = 9'b000000001,
      ST_IDLE    = 9'b000000010,
      ST_PROBE   = 9'b000000100,
      ST_COMPARE = 9'b000001000,
      ST_SHIFT   = 9'b000010000,
      ST_INSERT  = 9'b000100000,
      ST_VREAD   = 9'b001000000,
      ST_VDECODE = 9'b010000000,
      ST_DONE    = 9'b100000000
   } state_type;

   // The key flips the sign bit so that unsigned order follows signed order,
   // and the top bit marks plus infinity above every finite value.
   function automatic key_type make_key(logic [VALUE_WIDTH-1:0] value, logic is_inf);
      key_type key;
      if (is_inf) begin
         key = {1'b1, {VALUE_WIDTH{1'b0}}};
      end else begin
         key = {1'b0, value ^ {1'b1, {(VALUE_WIDTH-1){1'b0}}}};
      end
      return key;
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] key_value(key_type key);
      return key[VALUE_WIDTH-1:0] ^ {1'b1, {(VALUE_WIDTH-1){1'b0}}};
   endfunction

   // Keys of the three entries present after reset: zero, one and infinity.
   function automatic key_type reset_key(logic [INIT_WIDTH-1:0] idx);
      key_type key;
      unique case (idx)
         INIT_WIDTH'(0): key = make_key(VALUE_WIDTH'(0), 1'b0);
         INIT_WIDTH'(1): key = make_key(VALUE_WIDTH'(1), 1'b0);
         default:        key = make_key(VALUE_WIDTH'(0), 1'b1);
      endcase
      return key;
   endfunction

endpackage

### hdl/svit_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module svit_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### hdl/sorted_value_intern_table_top.sv
// Top level of the sorted value intern table with its search and shift sequencer.
//
//   port group | role          | dir | contents
//   req_       | request beat  | in  | tuser opcode, tdata operands
//   rsp_       | response beat | out | tdata handle, flags and read value
//
// A read passes through the value read and decode states. An intern takes a probe
// and a compare state per binary search step (at most 11 steps), and an insert moves
// each pair above its place up one, one at a time through the single write port of
// the pair RAM. After reset the block writes the three initial entries before it
// accepts a request. A held response stalls only the transfer of the next result.
`timescale 1ns / 1ps

module sorted_value_intern_table_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [31:0] bound_value, [32] bound_is_infinite, [42:33] query_handle
   input  logic [47:0] req_tdata,
   // [0] opcode
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [9:0] result_handle, [10] already_present, [11] table_full,
   // [43:12] read_value, [44] read_is_infinite
   output logic [47:0] rsp_tdata
);

   localparam int AW = svit_pkg::ADDR_WIDTH;
   localparam int CW = svit_pkg::COUNT_WIDTH;
   localparam int KW = svit_pkg::KEY_WIDTH;
   localparam int VW = svit_pkg::VALUE_WIDTH;
   localparam int IW = svit_pkg::INIT_WIDTH;

   svit_pkg::state_type state_ff, state_in;
   svit_pkg::count_type count_ff, count_in;
   svit_pkg::count_type lo_ff, lo_in;
   svit_pkg::count_type hi_ff, hi_in;
   svit_pkg::count_type shift_ff, shift_in;
   svit_pkg::addr_type  mid_ff, mid_in;
   svit_pkg::addr_type  wr_ptr_ff, wr_ptr_in;
   svit_pkg::addr_type  query_ff, query_in;
   svit_pkg::key_type   key_ff, key_in;
   logic [IW-1:0]       init_ff, init_in;
   logic                pend_ff, pend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [47:0]         rsp_data_ff, rsp_data_in;

   logic [AW-1:0] res_handle_ff, res_handle_in;
   logic          res_present_ff, res_present_in;
   logic          res_full_ff, res_full_in;
   logic [VW-1:0] res_value_ff, res_value_in;
   logic          res_inf_ff, res_inf_in;

   logic                         pair_wr_en, val_wr_en;
   svit_pkg::addr_type           pair_wr_addr, pair_rd_addr, val_wr_addr, val_rd_addr;
   logic [svit_pkg::PAIR_WIDTH-1:0] pair_wr_data, pair_rd_data;
   svit_pkg::key_type            val_wr_data, val_rd_data;
   svit_pkg::key_type            rd_key;
   svit_pkg::addr_type           rd_handle;
   svit_pkg::count_type          mid_calc;
   logic                         req_accept;

   assign rd_key     = pair_rd_data[svit_pkg::PAIR_WIDTH-1:AW];
   assign rd_handle  = pair_rd_data[AW-1:0];
   assign req_tready = (state_ff == svit_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign mid_calc   = lo_ff + ((hi_ff - lo_ff) >> 1);

   svit_ram #(.WIDTH(svit_pkg::PAIR_WIDTH), .DEPTH(svit_pkg::CAPACITY)) u_pair_ram (
      .clock   (clock),
      .wr_en   (pair_wr_en),
      .wr_addr (pair_wr_addr),
      .wr_data (pair_wr_data),
      .rd_addr (pair_rd_addr),
      .rd_data (pair_rd_data)
   );

   svit_ram #(.WIDTH(KW), .DEPTH(svit_pkg::CAPACITY)) u_value_ram (
      .clock   (clock),
      .wr_en   (val_wr_en),
      .wr_addr (val_wr_addr),
      .wr_data (val_wr_data),
      .rd_addr (val_rd_addr),
      .rd_data (val_rd_data)
   );

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      shift_in       = shift_ff;
      mid_in         = mid_ff;
      wr_ptr_in      = wr_ptr_ff;
      query_in       = query_ff;
      key_in         = key_ff;
      init_in        = init_ff;
      pend_in        = pend_ff;
      res_handle_in  = res_handle_ff;
      res_present_in = res_present_ff;
      res_full_in    = res_full_ff;
      res_value_in   = res_value_ff;
      res_inf_in     = res_inf_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      pair_wr_en     = 1'b0;
      pair_wr_addr   = wr_ptr_ff;
      pair_wr_data   = pair_rd_data;
      pair_rd_addr   = mid_ff;
      val_wr_en      = 1'b0;
      val_wr_addr    = count_ff[AW-1:0];
      val_wr_data    = key_ff;
      val_rd_addr    = query_ff;

      unique case (state_ff)
         svit_pkg::ST_INIT: begin
            pair_wr_en   = 1'b1;
            pair_wr_addr = AW'(init_ff);
            pair_wr_data = {svit_pkg::reset_key(init_ff), AW'(init_ff)};
            val_wr_en    = 1'b1;
            val_wr_addr  = AW'(init_ff);
            val_wr_data  = svit_pkg::reset_key(init_ff);
            init_in      = init_ff + IW'(1);
            if (init_ff == IW'(svit_pkg::RESET_COUNT - 1)) begin
               state_in = svit_pkg::ST_IDLE;
            end
         end
         svit_pkg::ST_IDLE: begin
            if (req_accept) begin
               key_in         = svit_pkg::make_key(req_tdata[VW-1:0], req_tdata[32]);
               query_in       = req_tdata[42:33];
               lo_in          = '0;
               hi_in          = count_ff;
               res_handle_in  = '0;
               res_present_in = 1'b0;
               res_full_in    = 1'b0;
               res_value_in   = '0;
               res_inf_in     = 1'b0;
               state_in       = req_tuser ? svit_pkg::ST_VREAD : svit_pkg::ST_PROBE;
            end
         end
         svit_pkg::ST_PROBE: begin
            if (lo_ff < hi_ff) begin
               pair_rd_addr = mid_calc[AW-1:0];
               mid_in       = mid_calc[AW-1:0];
               state_in     = svit_pkg::ST_COMPARE;
            end else if (count_ff >= CW'(svit_pkg::CAPACITY)) begin
               res_full_in = 1'b1;
               state_in    = svit_pkg::ST_DONE;
            end else begin
               shift_in = count_ff;
               pend_in  = 1'b0;
               state_in = svit_pkg::ST_SHIFT;
            end
         end
         svit_pkg::ST_COMPARE: begin
            priority if (key_ff < rd_key) begin
               hi_in    = {1'b0, mid_ff};
               state_in = svit_pkg::ST_PROBE;
            end else if (key_ff > rd_key) begin
               lo_in    = {1'b0, mid_ff} + CW'(1);
               state_in = svit_pkg::ST_PROBE;
            end else begin
               res_handle_in  = rd_handle;
               res_present_in = 1'b1;
               state_in       = svit_pkg::ST_DONE;
            end
         end
         svit_pkg::ST_SHIFT: begin
            // The pair read in the previous cycle lands one place higher.
            pair_wr_en = pend_ff;
            if (shift_ff != lo_ff) begin
               pair_rd_addr = AW'(shift_ff - CW'(1));
               wr_ptr_in    = shift_ff[AW-1:0];
               shift_in     = shift_ff - CW'(1);
               pend_in      = 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = svit_pkg::ST_INSERT;
            end
         end
         svit_pkg::ST_INSERT: begin
            pair_wr_en    = 1'b1;
            pair_wr_addr  = lo_ff[AW-1:0];
            pair_wr_data  = {key_ff, count_ff[AW-1:0]};
            val_wr_en     = 1'b1;
            res_handle_in = count_ff[AW-1:0];
            count_in      = count_ff + CW'(1);
            state_in      = svit_pkg::ST_DONE;
         end
         svit_pkg::ST_VREAD: begin
            state_in = ({1'b0, query_ff} < count_ff) ? svit_pkg::ST_VDECODE
                                                      : svit_pkg::ST_DONE;
         end
         svit_pkg::ST_VDECODE: begin
            if (val_rd_data[KW-1]) begin
               res_inf_in = 1'b1;
            end else begin
               res_value_in = svit_pkg::key_value(val_rd_data);
            end
            state_in = svit_pkg::ST_DONE;
         end
         svit_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {3'b000, res_inf_ff, res_value_ff, res_full_ff,
                               res_present_ff, res_handle_ff};
               rsp_valid_in = 1'b1;
               state_in     = svit_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = svit_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= svit_pkg::ST_INIT;
         count_ff     <= CW'(svit_pkg::RESET_COUNT);
         init_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         init_ff      <= init_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      shift_ff       <= shift_in;
      mid_ff         <= mid_in;
      wr_ptr_ff      <= wr_ptr_in;
      query_ff       <= query_in;
      key_ff         <= key_in;
      res_handle_ff  <= res_handle_in;
      res_present_ff <= res_present_in;
      res_full_ff    <= res_full_in;
      res_value_ff   <= res_value_in;
      res_inf_ff     <= res_inf_in;
      rsp_data_ff    <= rsp_data_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(svit_pkg::CAPACITY))
      else $error("Entry count exceeds capacity.");

   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == svit_pkg::ST_SHIFT) |-> (shift_ff >= lo_ff))
      else $error("Shift pointer fell below the insert position.");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == svit_pkg::ST_INSERT) |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("Insert did not advance the entry count.");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff[10] && rsp_data_ff[11]))
      else $error("Response reports both present and full.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("Stalled response beat changed.");

endmodule

### verif/sorted_value_intern_table_top_tb.sv
// Self-checking testbench for the sorted value intern table: directed and random beats.
`timescale 1ns / 1ps

module sorted_value_intern_table_top_tb;

   localparam int AW          = svit_pkg::ADDR_WIDTH;
   localparam int CYCLE_LIMIT = 10_000_000;
   localparam int TAIL_CYCLES = 40;

   typedef enum logic {
      OP_INTERN = 1'b0,
      OP_READ   = 1'b1
   } opcode_type;

   typedef struct packed {
      logic [svit_pkg::ADDR_WIDTH-1:0]  handle;
      logic                             present;
      logic                             full;
      logic [svit_pkg::VALUE_WIDTH-1:0] value;
      logic                             is_inf;
   } table_answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;

   table_answer_type pending_answers[$];
   logic [svit_pkg::KEY_WIDTH-1:0] key_of_handle[svit_pkg::CAPACITY];
   int handle_of_key[logic [svit_pkg::KEY_WIDTH-1:0]];
   int entries;
   int error_count = 0;
   int cycle_count = 0;
   int stall_left = 0;
   bit quiet = 1'b0;

   sorted_value_intern_table_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic void clear_table();
      handle_of_key.delete();
      key_of_handle[0] = {1'b0, 32'sd0};
      key_of_handle[1] = {1'b0, 32'sd1};
      key_of_handle[2] = {1'b1, 32'd0};
      for (int h = 0; h < svit_pkg::RESET_COUNT; h++) begin
         handle_of_key[key_of_handle[h]] = h;
      end
      entries = svit_pkg::RESET_COUNT;
   endfunction

   function automatic table_answer_type intern_or_read(input opcode_type op,
                                                       input logic [31:0] value,
                                                       input logic inf,
                                                       input logic [9:0] query);
      table_answer_type answer;
      logic [svit_pkg::KEY_WIDTH-1:0] key;
      answer = '0;
      if (op == OP_INTERN) begin
         key = inf ? {1'b1, 32'd0} : {1'b0, value};
         if (handle_of_key.exists(key)) begin
            answer.handle  = AW'(handle_of_key[key]);
            answer.present = 1'b1;
         end else if (entries >= svit_pkg::CAPACITY) begin
            answer.full = 1'b1;
         end else begin
            handle_of_key[key]     = entries;
            key_of_handle[entries] = key;
            answer.handle          = AW'(entries);
            entries++;
         end
      end else if (int'(query) < entries) begin
         key = key_of_handle[query];
         if (key[svit_pkg::VALUE_WIDTH]) begin
            answer.is_inf = 1'b1;
         end else begin
            answer.value = key[svit_pkg::VALUE_WIDTH-1:0];
         end
      end
      return answer;
   endfunction

   function automatic logic [31:0] random_value();
      logic [31:0] v;
      v = $urandom;
      if ($urandom_range(0, 3) == 0) begin
         v = 32'($signed($urandom_range(0, 16)) - 8);
      end
      return v;
   endfunction

   task automatic send_beat(input opcode_type op, input logic [31:0] value,
                            input logic inf, input logic [9:0] query);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {5'b0, query, inf, value};
      do @(posedge clock); while (!req_tready);
      pending_answers.push_back(intern_or_read(op, value, inf, query));
   endtask

   task automatic settle_results();
      req_tvalid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   task automatic test_reset_contents();
      send_beat(OP_READ, 32'hFFFF_FFFF, 1'b1, 10'd0);
      send_beat(OP_READ, 32'd0, 1'b0, 10'd1);
      send_beat(OP_READ, 32'd0, 1'b0, 10'd2);
      send_beat(OP_READ, 32'd0, 1'b0, 10'd3);
      send_beat(OP_READ, 32'd0, 1'b0, 10'd1023);
   endtask

   task automatic test_intern_edges();
      send_beat(OP_INTERN, 32'd0, 1'b0, 10'd1023);
      send_beat(OP_INTERN, 32'hFFFF_FFFF, 1'b1, 10'd0);
      send_beat(OP_INTERN, 32'h8000_0000, 1'b0, 10'd0);
      send_beat(OP_INTERN, 32'h7FFF_FFFF, 1'b0, 10'd0);
      send_beat(OP_INTERN, 32'hFFFF_FFFF, 1'b0, 10'd0);
      send_beat(OP_INTERN, 32'hFFFF_FFFF, 1'b0, 10'd0);
      send_beat(OP_INTERN, 32'd0, 1'b1, 10'd0);
      send_beat(OP_INTERN, 32'd1, 1'b0, 10'd0);
      send_beat(OP_READ, 32'd0, 1'b0, 10'd3);
      send_beat(OP_READ, 32'd0, 1'b0, 10'd4);
      send_beat(OP_READ, 32'd0, 1'b0, 10'd5);
      send_beat(OP_READ, 32'd0, 1'b0, 10'd6);
      send_beat(OP_READ, 32'd0, 1'b0, 10'd2);
   endtask

   task automatic test_random_mix(input int beats, input bit calm);
      int pick;
      logic [svit_pkg::KEY_WIDTH-1:0] key;
      for (int i = 0; i < beats; i++) begin
         if (i % 40 == 0) begin
            quiet = calm || ($urandom_range(0, 5) == 0);
         end
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            send_beat(OP_INTERN, random_value(), 1'b0, 10'($urandom));
         end else if (pick < 65) begin
            key = key_of_handle[$urandom_range(0, entries - 1)];
            send_beat(OP_INTERN,
                      key[svit_pkg::VALUE_WIDTH] ? 32'($urandom)
                                                 : key[svit_pkg::VALUE_WIDTH-1:0],
                      key[svit_pkg::VALUE_WIDTH], 10'($urandom));
         end else if (pick < 70) begin
            send_beat(OP_INTERN, 32'($urandom), 1'b1, 10'($urandom));
         end else if (pick < 90) begin
            send_beat(OP_READ, 32'($urandom), 1'($urandom),
                      10'($urandom_range(0, entries - 1)));
         end else begin
            send_beat(OP_READ, 32'($urandom), 1'($urandom), 10'($urandom));
         end
      end
      quiet = calm;
   endtask

   always @(posedge clock) begin
      table_answer_type got;
      table_answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.handle  = rsp_tdata[9:0];
         got.present = rsp_tdata[10];
         got.full    = rsp_tdata[11];
         got.value   = rsp_tdata[43:12];
         got.is_inf  = rsp_tdata[44];
         if (pending_answers.size() == 0) begin
            report_mismatch("unexpected beat", 64'(rsp_tdata), 64'd0);
         end else begin
            want = pending_answers.pop_front();
            if (got.handle !== want.handle)
               report_mismatch("result_handle", 64'(got.handle), 64'(want.handle));
            if (got.present !== want.present)
               report_mismatch("already_present", 64'(got.present), 64'(want.present));
            if (got.full !== want.full)
               report_mismatch("table_full", 64'(got.full), 64'(want.full));
            if (got.value !== want.value)
               report_mismatch("read_value", 64'(got.value), 64'(want.value));
            if (got.is_inf !== want.is_inf)
               report_mismatch("read_is_infinite", 64'(got.is_inf), 64'(want.is_inf));
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
         stall_left = $urandom_range(1, 10) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sorted_value_intern_table_top regression: fail");
         $finish;
      end
   end

   initial begin
      clear_table();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_contents();
      test_intern_edges();
      settle_results();
      test_random_mix(480, 1'b0);
      settle_results();
      test_random_mix(72, 1'b1);
      settle_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("sorted_value_intern_table_top regression: pass");
      end else begin
         $display("sorted_value_intern_table_top regression: fail");
      end
      $finish;
   end

endmodule

### files.f
hdl/svit_pkg.sv
hdl/svit_ram.sv
hdl/sorted_value_intern_table_top.sv
verif/sorted_value_intern_table_top_tb.sv
